>>> sv/dadd_pkg.sv
`timescale 1ns / 1ps
// Shared constants and calendar helpers for the week-rollover date corrector.
// No dependencies.
package dadd_pkg;

  localparam int YearW  = 7;   // years since 2000 at the ports
  localparam int MonthW = 4;
  localparam int DayW   = 5;
  localparam int YrW    = 8;   // internal year, holds up to 127 + 19 + 1
  localparam int DoyW   = 10;  // day of year plus shift, up to 595
  localparam int MsW    = 9;   // month start offsets, up to 334

  localparam logic [DoyW-1:0]   DaysShift    = 10'd228;  // 233 - 5
  localparam logic [YrW-1:0]    YearsShift   = 8'd19;
  localparam logic [DoyW-1:0]   BaseYearDays = 10'd365;
  localparam logic [YrW-1:0]    LastYear     = 8'd99;
  localparam logic [1:0]        LeapMask     = 2'b11;
  localparam logic [MonthW-1:0] MonthJan     = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb     = 4'd2;
  localparam logic [MonthW-1:0] MonthMar     = 4'd3;
  localparam logic [MonthW-1:0] MonthDec     = 4'd12;
  localparam int                NumMonths    = 12;

  // cumulative days before each month, non-leap year; index 0 is January
  function automatic logic [MsW-1:0] month_start(input logic [MonthW-1:0] idx);
    logic [MsW-1:0] r;
    case (idx)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      4'd11:   r = 9'd334;
      default: r = 9'd334;
    endcase
    return r;
  endfunction

  function automatic logic is_leap(input logic [YrW-1:0] yr);
    return (yr[1:0] & LeapMask) == 2'b00;
  endfunction

endpackage

>>> sv/date_add_1024_weeks_top.sv
`timescale 1ns / 1ps
// Top level of the week-rollover date corrector: three-stage pipeline.
// Depends on dadd_pkg and dadd_doy2md.

// Adds 1024 weeks to a date given as years since 2000, month and day. A date is
// taken on any cycle with start_i high (busy_o is always low), and its result
// appears for one cycle with valid_o high after the three register stages (day
// of year and year shift, day shift and rollover, month/day conversion); one date
// per clock. The receiver cannot stall the block.
// When the corrected year passes 99, out_of_range_o is high and the date fields are 0.
module date_add_1024_weeks_top import dadd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [YearW-1:0]  year_in_i,
  input  logic [MonthW-1:0] month_in_i,
  input  logic [DayW-1:0]   day_in_i,
  output logic              valid_o,
  output logic [YearW-1:0]  year_out_o,
  output logic [MonthW-1:0] month_out_o,
  output logic [DayW-1:0]   day_out_o,
  output logic              out_of_range_o
);

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // stage 1: day of year, year shifted
  logic              v1_q;
  logic [YrW-1:0]    yr1_d, yr1_q;
  logic [DoyW-1:0]   doy1_d, doy1_q;
  logic [MonthW-1:0] mo_c;

  always_comb begin
    if (month_in_i < MonthJan)      mo_c = MonthJan;
    else if (month_in_i > MonthDec) mo_c = MonthDec;
    else                            mo_c = month_in_i;
    doy1_d = DoyW'(month_start(mo_c - MonthW'(1))) + DoyW'(day_in_i)
             + DoyW'(is_leap(YrW'(year_in_i)) && (mo_c >= MonthMar));
    yr1_d  = YrW'(year_in_i) + YearsShift;
  end

  // stage 2: day shift and rollover
  logic              v2_q;
  logic [YrW-1:0]    yr2_d, yr2_q;
  logic [DoyW-1:0]   doy2_d, doy2_q;
  logic [DoyW-1:0]   doy_sh, year_len;
  logic              lp1;

  always_comb begin
    lp1      = is_leap(yr1_q);
    doy_sh   = doy1_q + DaysShift + DoyW'(lp1);
    year_len = BaseYearDays + DoyW'(lp1);
    if (doy_sh > year_len) begin
      doy2_d = doy_sh - year_len;
      yr2_d  = yr1_q + YrW'(1);
    end else begin
      doy2_d = doy_sh;
      yr2_d  = yr1_q;
    end
  end

  // stage 3: back to month and day
  logic [MonthW-1:0] mo3;
  logic [DayW-1:0]   dy3;
  logic              oor3;

  dadd_doy2md u_doy2md (
    .doy_i   (doy2_q),
    .leap_i  (is_leap(yr2_q)),
    .month_o (mo3),
    .day_o   (dy3)
  );

  assign oor3 = yr2_q > LastYear;

  logic              v3_q;
  logic [YearW-1:0]  yr3_q;
  logic [MonthW-1:0] mo3_q;
  logic [DayW-1:0]   dy3_q;
  logic              oor3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    yr1_q  <= yr1_d;
    doy1_q <= doy1_d;
    yr2_q  <= yr2_d;
    doy2_q <= doy2_d;
    oor3_q <= oor3;
    if (oor3) begin
      yr3_q <= '0;
      mo3_q <= '0;
      dy3_q <= '0;
    end else begin
      yr3_q <= yr2_q[YearW-1:0];
      mo3_q <= mo3;
      dy3_q <= dy3;
    end
  end

  assign valid_o        = v3_q;
  assign year_out_o     = yr3_q;
  assign month_out_o    = mo3_q;
  assign day_out_o      = dy3_q;
  assign out_of_range_o = oor3_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(v2_q))
    else $error("result strobe without a transfer in flight");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && out_of_range_o) |->
      (year_out_o == '0 && month_out_o == '0 && day_out_o == '0))
    else $error("out-of-range result carries a date");

  a_date_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !out_of_range_o) |->
      (month_out_o >= MonthJan && month_out_o <= MonthDec && day_out_o != '0
       && year_out_o <= YearW'(LastYear)))
    else $error("corrected date out of calendar range");

  a_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |=> v2_q)
    else $error("pipeline lost a transfer");

endmodule

>>> sv/dadd_doy2md.sv
`timescale 1ns / 1ps
// Converts a day of year into month and day of month, leap February aware.
// Depends on dadd_pkg.
module dadd_doy2md import dadd_pkg::*; (
  input  logic [DoyW-1:0]   doy_i,
  input  logic              leap_i,
  output logic [MonthW-1:0] month_o,
  output logic [DayW-1:0]   day_o
);

  logic              hide;
  logic [DoyW-1:0]   doy_adj;
  logic [MonthW-1:0] cnt;
  logic [DoyW-1:0]   rem;

  always_comb begin
    // drop Feb 29 so the plain table applies; put it back for February
    hide    = leap_i && (doy_i > DoyW'(month_start(4'd2)));
    doy_adj = doy_i - DoyW'(hide);
    cnt     = '0;
    for (int k = 1; k < NumMonths; k++) begin
      if (doy_adj > DoyW'(month_start(MonthW'(k)))) cnt = cnt + MonthW'(1);
    end
    month_o = cnt + MonthW'(1);
    rem     = doy_adj - DoyW'(month_start(cnt))
              + DoyW'(hide && (month_o == MonthFeb));
    day_o   = rem[DayW-1:0];
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Testbench for date_add_1024_weeks_top: drives dates through the command port
// and checks every strobed result against an in-bench calendar predictor.
// Depends on dadd_pkg and the date_add_1024_weeks_top RTL.
module tb;
  import dadd_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int MaxReported = 10;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic              oor;
  } date_result_t;

  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              start_i    = 1'b0;
  logic [YearW-1:0]  year_in_i  = '0;
  logic [MonthW-1:0] month_in_i = '0;
  logic [DayW-1:0]   day_in_i   = '0;
  logic              busy_o;
  logic              valid_o;
  logic [YearW-1:0]  year_out_o;
  logic [MonthW-1:0] month_out_o;
  logic [DayW-1:0]   day_out_o;
  logic              out_of_range_o;

  date_result_t expected_dates[$];
  date_result_t want_date;
  date_result_t got_date;
  int           error_count = 0;
  int           cycle_count = 0;
  int           idle_pct    = 0;

  date_add_1024_weeks_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .year_in_i     (year_in_i),
    .month_in_i    (month_in_i),
    .day_in_i      (day_in_i),
    .valid_o       (valid_o),
    .year_out_o    (year_out_o),
    .month_out_o   (month_out_o),
    .day_out_o     (day_out_o),
    .out_of_range_o(out_of_range_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------------
  function automatic logic [MsW-1:0] days_before_month(input logic [MonthW-1:0] idx);
    case (idx)
      4'd0:    return 9'd0;
      4'd1:    return 9'd31;
      4'd2:    return 9'd59;
      4'd3:    return 9'd90;
      4'd4:    return 9'd120;
      4'd5:    return 9'd151;
      4'd6:    return 9'd181;
      4'd7:    return 9'd212;
      4'd8:    return 9'd243;
      4'd9:    return 9'd273;
      4'd10:   return 9'd304;
      default: return 9'd334;
    endcase
  endfunction

  function automatic logic leap_year(input logic [YrW-1:0] yr);
    return yr[1:0] == 2'b00;
  endfunction

  function automatic date_result_t shift_1024_weeks(input logic [YearW-1:0] y,
                                                    input logic [MonthW-1:0] m,
                                                    input logic [DayW-1:0] d);
    date_result_t     r;
    logic [YrW-1:0]   yr;
    logic [MonthW-1:0] mo;
    logic [DoyW-1:0]  doy;
    logic [DoyW-1:0]  year_len;
    logic             hide;
    yr = {1'b0, y};
    mo = m;
    if (mo < MonthJan) mo = MonthJan;
    if (mo > MonthDec) mo = MonthDec;
    doy = DoyW'(days_before_month(mo - 4'd1)) + DoyW'(d);
    if (leap_year(yr) && mo >= MonthMar) doy = doy + 10'd1;
    yr = yr + YearsShift;
    doy = doy + DaysShift + DoyW'(leap_year(yr));
    year_len = BaseYearDays + DoyW'(leap_year(yr));
    // only one rollover is ever applied
    if (doy > year_len) begin
      doy = doy - year_len;
      yr = yr + 8'd1;
    end
    // leap year: drop Feb 29 for the table search, restore it afterwards
    hide = leap_year(yr) && (doy > DoyW'(days_before_month(4'd2)));
    if (hide) doy = doy - 10'd1;
    mo = MonthJan;
    for (int k = 1; k < NumMonths; k++) begin
      if (doy > DoyW'(days_before_month(MonthW'(k)))) mo = MonthW'(k + 1);
    end
    doy = doy - DoyW'(days_before_month(mo - 4'd1));
    if (hide && mo == MonthFeb) doy = doy + 10'd1;
    r = '0;
    if (yr > LastYear) begin
      r.oor = 1'b1;
    end else begin
      r.year  = yr[YearW-1:0];
      r.month = mo;
      r.day   = doy[DayW-1:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: push on accepted transfer, pop and compare on strobe
  // ---------------------------------------------------------------------------
  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= MaxReported) $display("ERROR @%0t: %s", $time, msg);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        expected_dates.push_back(shift_1024_weeks(year_in_i, month_in_i, day_in_i));
      end
      if (valid_o) begin
        got_date = '{year_out_o, month_out_o, day_out_o, out_of_range_o};
        if (expected_dates.size() == 0) begin
          note_error($sformatf("unexpected result y=%0d m=%0d d=%0d oor=%0b",
                               got_date.year, got_date.month, got_date.day, got_date.oor));
        end else begin
          want_date = expected_dates.pop_front();
          if (got_date.year != want_date.year || got_date.month != want_date.month ||
              got_date.day != want_date.day || got_date.oor != want_date.oor) begin
            note_error($sformatf("exp y=%0d m=%0d d=%0d oor=%0b, got y=%0d m=%0d d=%0d oor=%0b",
                                 want_date.year, want_date.month, want_date.day, want_date.oor,
                                 got_date.year, got_date.month, got_date.day, got_date.oor));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("date_add_1024_weeks_top test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic send_date(input logic [YearW-1:0] y, input logic [MonthW-1:0] m,
                           input logic [DayW-1:0] d);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i    <= 1'b1;
    year_in_i  <= y;
    month_in_i <= m;
    day_in_i   <= d;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic test_field_extremes();
    send_date(7'd0, 4'd1, 5'd1);
    send_date(7'd0, 4'd0, 5'd0);     // month 0 clamps to January, day 0
    send_date(7'd99, 4'd12, 5'd31);
    send_date(7'd127, 4'd15, 5'd31); // year above 99
    send_date(7'd0, 4'd13, 5'd5);    // month above 12 clamps to December
    send_date(7'd5, 4'd6, 5'd0);
    send_date(7'd2, 4'd7, 5'd31);
    send_date(7'd42, 4'd10, 5'd30);
  endtask

  task automatic test_leap_days();
    send_date(7'd1, 4'd2, 5'd29);    // past end of February in a common year
    send_date(7'd4, 4'd2, 5'd29);
    send_date(7'd4, 4'd3, 5'd1);
    send_date(7'd96, 4'd6, 5'd15);
    send_date(7'd9, 4'd5, 5'd18);    // rollover lands on January 1 of the result year
    send_date(7'd3, 4'd11, 5'd30);
    send_date(7'd3, 4'd12, 5'd1);    // late day of year, result falls in July
    send_date(7'd11, 4'd8, 5'd14);
  endtask

  task automatic test_year_limit();
    send_date(7'd79, 4'd12, 5'd31);
    send_date(7'd80, 4'd1, 5'd1);
    send_date(7'd80, 4'd12, 5'd31);  // rollover pushes past 99
    send_date(7'd81, 4'd1, 5'd1);
    send_date(7'd100, 4'd3, 5'd3);
  endtask

  task automatic test_random_dates(input int count, input int pct);
    logic [YearW-1:0]  y;
    logic [MonthW-1:0] m;
    logic [DayW-1:0]   d;
    int                dim;
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 15) begin
        // arbitrary bit patterns, including invalid months and days
        y = YearW'($urandom_range(127));
        m = MonthW'($urandom_range(15));
        d = DayW'($urandom_range(31));
      end else begin
        y = YearW'($urandom_range(99));
        m = MonthW'($urandom_range(1, 12));
        case (m)
          4'd2:                      dim = (y[1:0] == 2'b00) ? 29 : 28;
          4'd4, 4'd6, 4'd9, 4'd11:   dim = 30;
          default:                   dim = 31;
        endcase
        d = DayW'($urandom_range(dim, 1));
      end
      send_date(y, m, d);
    end
  endtask

  initial begin
    int waited;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 0;
    test_field_extremes();
    test_leap_days();
    test_year_limit();

    test_random_dates(350, 0);
    test_random_dates(350, 58);
    test_random_dates(350, 0);
    test_random_dates(350, 37);
    start_i <= 1'b0;

    waited = 0;
    while (expected_dates.size() != 0 && waited < 1000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (10) @(posedge clk_i);
    if (expected_dates.size() != 0) begin
      note_error($sformatf("%0d results never arrived", expected_dates.size()));
    end

    if (error_count == 0) begin
      $display("date_add_1024_weeks_top test passed");
    end else begin
      $display("date_add_1024_weeks_top test failed");
    end
    $finish;
  end

endmodule
